[src/ddo_pkg.sv]
// Shared types, constants and the microcode program for the odometry block.
package ddo_pkg;

	localparam int CORDIC_STEPS = 16;
	localparam int ATAN_DEPTH   = 24;
	localparam int IDX_W        = $clog2(ATAN_DEPTH);
	localparam int UPC_W        = 5;

	localparam logic [15:0] FULL_TURN_CDEG = 16'd36000;
	localparam logic [15:0] QUARTER_CDEG   = 16'd9000;
	localparam logic [15:0] HALF_CDEG      = 16'd18000;
	localparam logic [15:0] THREEQ_CDEG    = 16'd27000;
	localparam logic [15:0] WD_RESET       = 16'd1024;

	localparam logic signed [27:0] PI_Q16          = 28'sd205887;
	localparam logic signed [27:0] CDEG_TO_RAD_Q30 = 28'sd187403;
	localparam logic signed [32:0] CORDIC_GAIN_Q30 = 33'sd652032874;

	// datapath operations, one per microcode step
	typedef enum logic [3:0] {
		OP_NOP, OP_MUL_LO, OP_MUL_HI, OP_CIRC, OP_SUM, OP_DIST, OP_QUAD,
		OP_CINIT, OP_CSTEP, OP_TRIG, OP_ADDX, OP_ADDY, OP_LOADXY, OP_FIN
	} uop_t;

	// multiplier operand A
	typedef enum logic [1:0] {MA_WD, MA_SUM, MA_R, MA_DIST} ma_t;

	// multiplier operand B
	typedef enum logic [2:0] {MB_PI, MB_CIRC, MB_RAD, MB_SIN, MB_COS} mb_t;

	// jump conditions
	typedef enum logic [1:0] {J_NONE, J_ALWAYS, J_KIND, J_ITER} jcond_t;

	typedef struct packed {
		uop_t                op;
		ma_t                 ma;
		mb_t                 mb;
		jcond_t              jc;
		logic [UPC_W-1:0]    tgt;
	} uword_t;

	localparam logic [UPC_W-1:0] ST_CSTEP  = 5'd9;
	localparam logic [UPC_W-1:0] ST_LOADXY = 5'd17;
	localparam logic [UPC_W-1:0] ST_FIN    = 5'd18;

	function automatic uword_t ucode(input logic [UPC_W-1:0] pc);
		uword_t w;
		w = '{op: OP_NOP, ma: MA_WD, mb: MB_PI, jc: J_NONE, tgt: '0};
		case (pc)
			5'd0: w = '{op: OP_MUL_LO, ma: MA_WD, mb: MB_PI, jc: J_KIND, tgt: ST_LOADXY};
			5'd1: w.op = OP_CIRC;
			5'd2: w.op = OP_SUM;
			5'd3: w = '{op: OP_MUL_LO, ma: MA_SUM, mb: MB_CIRC, jc: J_NONE, tgt: '0};
			5'd4: w = '{op: OP_MUL_HI, ma: MA_SUM, mb: MB_CIRC, jc: J_NONE, tgt: '0};
			5'd5: w.op = OP_DIST;
			5'd6: w.op = OP_QUAD;
			5'd7: w = '{op: OP_MUL_LO, ma: MA_R, mb: MB_RAD, jc: J_NONE, tgt: '0};
			5'd8: w.op = OP_CINIT;
			5'd9: w = '{op: OP_CSTEP, ma: MA_WD, mb: MB_PI, jc: J_ITER, tgt: ST_CSTEP};
			5'd10: w.op = OP_TRIG;
			5'd11: w = '{op: OP_MUL_LO, ma: MA_DIST, mb: MB_SIN, jc: J_NONE, tgt: '0};
			5'd12: w = '{op: OP_MUL_HI, ma: MA_DIST, mb: MB_SIN, jc: J_NONE, tgt: '0};
			5'd13: w.op = OP_ADDX;
			5'd14: w = '{op: OP_MUL_LO, ma: MA_DIST, mb: MB_COS, jc: J_NONE, tgt: '0};
			5'd15: w = '{op: OP_MUL_HI, ma: MA_DIST, mb: MB_COS, jc: J_NONE, tgt: '0};
			5'd16: w = '{op: OP_ADDY, ma: MA_WD, mb: MB_PI, jc: J_ALWAYS, tgt: ST_FIN};
			5'd17: w.op = OP_LOADXY;
			5'd18: w.op = OP_FIN;
			default: w.op = OP_NOP;
		endcase
		return w;
	endfunction

	// arctangent of 2^-i, truncated Q.30
	function automatic logic signed [32:0] atan_q30(input logic [IDX_W-1:0] idx);
		logic signed [32:0] v;
		v = '0;
		case (idx)
			5'd0:  v = 33'sh03243F6A8;
			5'd1:  v = 33'sh01DAC6705;
			5'd2:  v = 33'sh00FADBAFC;
			5'd3:  v = 33'sh007F56EA6;
			5'd4:  v = 33'sh003FEAB76;
			5'd5:  v = 33'sh001FFD55B;
			5'd6:  v = 33'sh000FFFAAA;
			5'd7:  v = 33'sh0007FFF55;
			5'd8:  v = 33'sh0003FFFEA;
			5'd9:  v = 33'sh0001FFFFD;
			5'd10: v = 33'sh0000FFFFF;
			5'd11: v = 33'sh00007FFFF;
			5'd12: v = 33'sh00003FFFF;
			5'd13: v = 33'sh00001FFFF;
			5'd14: v = 33'sh00000FFFF;
			5'd15: v = 33'sh000007FFF;
			5'd16: v = 33'sh000003FFF;
			5'd17: v = 33'sh000001FFF;
			5'd18: v = 33'sh000000FFF;
			5'd19: v = 33'sh0000007FF;
			5'd20: v = 33'sh0000003FF;
			5'd21: v = 33'sh0000001FF;
			5'd22: v = 33'sh0000000FF;
			5'd23: v = 33'sh00000007F;
			default: v = '0;
		endcase
		return v;
	endfunction

	// round Q.30 to Q1.15, clamp to +-32767
	function automatic logic signed [15:0] to_q15(input logic signed [32:0] v);
		logic signed [33:0] t;
		logic signed [18:0] r;
		logic signed [15:0] o;
		t = {v[32], v} + 34'sd16384;
		r = t[33:15];
		if (r > 19'sd32767)
			o = 16'sd32767;
		else if (r < -19'sd32767)
			o = -16'sd32767;
		else
			o = r[15:0];
		return o;
	endfunction

	// clamp a 38-bit sum to the signed 32-bit range
	function automatic logic signed [31:0] sat32(input logic signed [37:0] v);
		logic signed [31:0] o;
		if (v > 38'sh007FFFFFFF)
			o = 32'sh7FFFFFFF;
		else if (v < -38'sh0080000000)
			o = 32'sh80000000;
		else
			o = v[31:0];
		return o;
	endfunction

endpackage

[src/differential_drive_odometry.sv]
// Differential-drive dead-reckoning odometry: microcoded sequencer and datapath.
//
// Usage
//   s_axis carries one item per update or position reset. tuser is the kind
//   (0 update, 1 reset); tdata packs left_revs, right_revs, heading_in,
//   set_x and set_y from the lowest bit up. Each item yields exactly one
//   item on m_axis: pos_x, pos_y, heading_out.
//   cfg_valid/cfg_data write the wheel diameter (Q8.8 inches, 4.0 at
//   reset); cfg_ready is always high. Write it only while the block is idle.
// Timing
//   An update runs 18 microcode steps; the CORDIC rotation step repeats
//   CORDIC_STEPS times. A reset item runs 3 steps. One item at a time:
//   s_axis_tready returns the cycle after the result is loaded. Wide
//   products take two steps on 18x28 partial products.
// Reset and stall
//   arst_n clears position, encoder baseline and the output valid, and sets
//   the wheel diameter to 4 inches. A stalled receiver holds the output
//   register; the next item is still accepted and computed, then waits in
//   its final step until the output register is free.
module differential_drive_odometry
	import ddo_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// [31:0] left_revs, [63:32] right_revs, [79:64] heading_in,
	// [111:80] set_x, [143:112] set_y
	input  logic [143:0] s_axis_tdata,
	// [0] kind
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// [31:0] pos_x, [63:32] pos_y, [79:64] heading_out
	output logic [79:0]  m_axis_tdata,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [15:0]  cfg_data
);

	// control
	logic             busy_q;
	logic [UPC_W-1:0] upc_q;
	logic [IDX_W-1:0] iter_q;
	logic             m_valid_q;
	logic [79:0]      m_data_q;
	uword_t           uw;
	logic             jump_taken;
	logic             out_free;
	logic             s_acc;
	logic             fin_go;

	// configuration and persistent state
	logic [15:0]        wd_q;
	logic signed [31:0] last_left_q;
	logic signed [31:0] last_right_q;
	logic signed [31:0] acc_x_q;
	logic signed [31:0] acc_y_q;

	// latched item
	logic               kind_q;
	logic signed [31:0] left_q;
	logic signed [31:0] right_q;
	logic [15:0]        hd_q;
	logic signed [31:0] set_x_q;
	logic signed [31:0] set_y_q;
	logic [15:0]        hd_in;
	logic [15:0]        hd_fixed;

	// working registers
	logic signed [63:0] prod_q;
	logic [25:0]        circ_q;
	logic signed [33:0] sum_q;
	logic signed [34:0] dist_q;
	logic [1:0]         quad_q;
	logic [13:0]        res_q;
	logic signed [32:0] cx_q;
	logic signed [32:0] cy_q;
	logic signed [32:0] cz_q;
	logic signed [15:0] sin_q;
	logic signed [15:0] cos_q;

	// datapath combinational
	logic signed [35:0] mul_a;
	logic signed [27:0] mul_b;
	logic signed [46:0] lo_pp;
	logic signed [45:0] hi_pp;
	logic signed [63:0] rnd_dist;
	logic signed [63:0] rnd_inc;
	logic [63:0]        rnd_circ;
	logic signed [37:0] inc38;
	logic signed [37:0] sum_x;
	logic signed [37:0] sum_y;
	logic [1:0]         quad_d;
	logic [15:0]        res_d;
	logic signed [32:0] dx;
	logic signed [32:0] dy;
	logic signed [32:0] atan_v;
	logic signed [15:0] s15;
	logic signed [15:0] c15;

	assign cfg_ready     = 1'b1;
	assign s_axis_tready = !busy_q;
	assign s_acc         = s_axis_tvalid && !busy_q;
	assign m_axis_tvalid = m_valid_q;
	assign m_axis_tdata  = m_data_q;
	assign out_free      = !m_valid_q || m_axis_tready;
	// final step hands its result to the output register
	assign fin_go        = busy_q && (uw.op == OP_FIN) && out_free;

	assign hd_in    = s_axis_tdata[79:64];
	assign hd_fixed = (hd_in >= FULL_TURN_CDEG) ? (hd_in - FULL_TURN_CDEG) : hd_in;

	assign uw = ucode(upc_q);

	always_comb begin
		case (uw.jc)
			J_ALWAYS: jump_taken = 1'b1;
			J_KIND:   jump_taken = kind_q;
			J_ITER:   jump_taken = (iter_q != IDX_W'(CORDIC_STEPS - 1));
			default:  jump_taken = 1'b0;
		endcase
	end

	// shared multiplier: A split into an unsigned low and a signed high half
	always_comb begin
		case (uw.ma)
			MA_WD:   mul_a = {20'b0, wd_q};
			MA_SUM:  mul_a = {{2{sum_q[33]}}, sum_q};
			MA_R:    mul_a = {22'b0, res_q};
			default: mul_a = {dist_q[34], dist_q};
		endcase
		case (uw.mb)
			MB_PI:   mul_b = PI_Q16;
			MB_CIRC: mul_b = {2'b0, circ_q};
			MB_RAD:  mul_b = CDEG_TO_RAD_Q30;
			MB_SIN:  mul_b = {{12{sin_q[15]}}, sin_q};
			default: mul_b = {{12{cos_q[15]}}, cos_q};
		endcase
		lo_pp = $signed({1'b0, mul_a[17:0]}) * mul_b;
		hi_pp = $signed(mul_a[35:18]) * mul_b;
	end

	// rounding of the product register for each consumer
	always_comb begin
		rnd_circ = prod_q + 64'd128;
		rnd_dist = prod_q + 64'sd16777216;
		rnd_inc  = prod_q + 64'sd16384;
		inc38    = rnd_inc[52:15];
		sum_x    = {{6{acc_x_q[31]}}, acc_x_q} + inc38;
		sum_y    = {{6{acc_y_q[31]}}, acc_y_q} + inc38;
	end

	// quadrant and residue of the heading
	always_comb begin
		if (hd_q < QUARTER_CDEG) begin
			quad_d = 2'd0;
			res_d  = hd_q;
		end else if (hd_q < HALF_CDEG) begin
			quad_d = 2'd1;
			res_d  = hd_q - QUARTER_CDEG;
		end else if (hd_q < THREEQ_CDEG) begin
			quad_d = 2'd2;
			res_d  = hd_q - HALF_CDEG;
		end else begin
			quad_d = 2'd3;
			res_d  = hd_q - THREEQ_CDEG;
		end
	end

	// operands of one CORDIC rotation, and the Q1.15 rounding of sin and cos
	always_comb begin
		dx     = cy_q >>> iter_q;
		dy     = cx_q >>> iter_q;
		atan_v = atan_q30(iter_q);
		s15    = to_q15(cy_q);
		c15    = to_q15(cx_q);
	end

	// sequencer and control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q       <= 1'b0;
			upc_q        <= '0;
			iter_q       <= '0;
			m_valid_q    <= 1'b0;
			wd_q         <= WD_RESET;
			last_left_q  <= '0;
			last_right_q <= '0;
			acc_x_q      <= '0;
			acc_y_q      <= '0;
		end else begin
			if (cfg_valid)
				wd_q <= cfg_data;
			if (fin_go)
				m_valid_q <= 1'b1;
			else if (m_axis_tready)
				m_valid_q <= 1'b0;
			if (s_acc) begin
				busy_q <= 1'b1;
				upc_q  <= '0;
			end else if (busy_q) begin
				if (uw.op == OP_FIN) begin
					if (out_free) begin
						busy_q       <= 1'b0;
						upc_q        <= '0;
						last_left_q  <= left_q;
						last_right_q <= right_q;
					end
				end else begin
					upc_q <= jump_taken ? uw.tgt : upc_q + 1'b1;
				end
				case (uw.op)
					OP_CINIT:  iter_q <= '0;
					OP_CSTEP:  iter_q <= iter_q + 1'b1;
					OP_ADDX:   acc_x_q <= sat32(sum_x);
					OP_ADDY:   acc_y_q <= sat32(sum_y);
					OP_LOADXY: begin
						acc_x_q <= set_x_q;
						acc_y_q <= set_y_q;
					end
					default: ;
				endcase
			end
		end
	end

	// item latch and datapath registers
	always_ff @(posedge clk) begin
		if (s_acc) begin
			kind_q  <= s_axis_tuser;
			left_q  <= s_axis_tdata[31:0];
			right_q <= s_axis_tdata[63:32];
			hd_q    <= hd_fixed;
			set_x_q <= s_axis_tdata[111:80];
			set_y_q <= s_axis_tdata[143:112];
		end else if (busy_q) begin
			case (uw.op)
				OP_MUL_LO: prod_q <= {{17{lo_pp[46]}}, lo_pp};
				OP_MUL_HI: prod_q <= prod_q + {hi_pp, 18'b0};
				OP_CIRC:   circ_q <= rnd_circ[33:8];
				OP_SUM:    sum_q  <= ({{2{left_q[31]}}, left_q} - {{2{last_left_q[31]}},
						last_left_q}) + ({{2{right_q[31]}}, right_q} -
						{{2{last_right_q[31]}}, last_right_q});
				OP_DIST:   dist_q <= rnd_dist[59:25];
				OP_QUAD: begin
					quad_q <= quad_d;
					res_q  <= res_d[13:0];
				end
				OP_CINIT: begin
					cx_q <= CORDIC_GAIN_Q30;
					cy_q <= '0;
					cz_q <= prod_q[32:0];
				end
				OP_CSTEP: begin
					if (!cz_q[32]) begin
						cx_q <= cx_q - dx;
						cy_q <= cy_q + dy;
						cz_q <= cz_q - atan_v;
					end else begin
						cx_q <= cx_q + dx;
						cy_q <= cy_q - dy;
						cz_q <= cz_q + atan_v;
					end
				end
				OP_TRIG: begin
					case (quad_q)
						2'd0: begin
							sin_q <= s15;
							cos_q <= c15;
						end
						2'd1: begin
							sin_q <= c15;
							cos_q <= -s15;
						end
						2'd2: begin
							sin_q <= -s15;
							cos_q <= -c15;
						end
						default: begin
							sin_q <= -c15;
							cos_q <= s15;
						end
					endcase
				end
				OP_FIN: begin
					if (out_free)
						m_data_q <= {hd_q, acc_y_q, acc_x_q};
				end
				default: ;
			endcase
		end
	end

endmodule
